// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== hdl/mm2_pkg.sv =====
`default_nettype none

package mm2_pkg;

  // hash constants
  localparam logic [31:0] MIX_M      = 32'h5bd1e995;
  localparam int          MIX_R      = 24;
  localparam int          FIN_S1     = 29;
  localparam int          FIN_S2     = 31;
  localparam logic [31:0] SEED_RESET = 32'h3dd3b51a;

  // default depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // command handed from the front to the back
  typedef struct packed {
    logic        has_word;  // mix word into the hash
    logic [31:0] word;
    logic        finish;    // finish the message after the word
    logic        has_tail;  // one to three tail bytes pending
    logic [23:0] tail;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/mm2_if.sv =====
`default_nettype none

// message byte channel
interface mm2_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;
  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last,
                output ready);
endinterface

// finished hash channel
interface mm2_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;
  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

// seed write channel
interface mm2_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/mm2_front.sv =====
`default_nettype none

module mm2_front import mm2_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  mm2_byte_if.sink   msg,
  input  wire logic  cfg_write,
  input  wire logic  queue_full,
  output logic       push,
  output cmd_t       cmd
);

  logic [23:0] pend;
  logic [1:0]  pend_cnt;
  logic [23:0] pend_next;
  logic [1:0]  pend_cnt_next;
  logic        accept;
  logic        word_done;

  assign msg.ready = !queue_full;
  assign accept    = msg.valid && msg.ready;
  assign word_done = msg.has_byte && (pend_cnt == 2'd3);

  // byte packing into little-endian words
  always_comb begin
    pend_next     = pend;
    pend_cnt_next = pend_cnt;
    if (msg.has_byte) begin
      if (word_done) begin
        pend_next     = '0;
        pend_cnt_next = 2'd0;
      end else begin
        case (pend_cnt)
          2'd0:    pend_next[7:0]   = msg.data_byte;
          2'd1:    pend_next[15:8]  = msg.data_byte;
          2'd2:    pend_next[23:16] = msg.data_byte;
          default: pend_next        = pend;
        endcase
        pend_cnt_next = pend_cnt + 2'd1;
      end
    end
  end

  // command for the back end
  always_comb begin
    cmd.has_word = word_done;
    cmd.word     = {msg.data_byte, pend};
    cmd.finish   = msg.last;
    cmd.has_tail = (pend_cnt_next != 2'd0);
    cmd.tail     = pend_next;
  end

  assign push = accept && (word_done || msg.last);

  // pending byte state
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      pend     <= '0;
      pend_cnt <= 2'd0;
    end else if (accept) begin
      if (msg.last) begin
        pend     <= '0;
        pend_cnt <= 2'd0;
      end else begin
        pend     <= pend_next;
        pend_cnt <= pend_cnt_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mm2_queue.sv =====
`default_nettype none

module mm2_queue import mm2_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && full)
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && empty)
  `ASSERT_PROP(a_count_up, clk, rst, (push && !pop) |=> count == $past(count) + CW'(1))

endmodule

`default_nettype wire

// ===== hdl/mm2_back.sv =====
`default_nettype none

module mm2_back import mm2_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_write,
  input  wire logic [31:0] cfg_data,
  input  cmd_t       head,
  input  wire logic  empty,
  output logic       pop,
  mm2_hash_if.source hash
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_K1   = 3'd1;
  localparam logic [2:0] S_K2   = 3'd2;
  localparam logic [2:0] S_H1   = 3'd3;
  localparam logic [2:0] S_H2   = 3'd4;
  localparam logic [2:0] S_F0   = 3'd5;
  localparam logic [2:0] S_F1   = 3'd6;
  localparam logic [2:0] S_F2   = 3'd7;

  logic [2:0]  state;
  cmd_t        cmd;
  logic [31:0] seed;
  logic [31:0] h;
  logic [31:0] k;
  logic [31:0] prod;
  logic [31:0] op;
  logic [31:0] mul_lo;
  logic [31:0] out_hash;
  logic        out_valid;
  logic        out_free;

  assign pop      = (state == S_IDLE) && !empty;
  assign out_free = !out_valid || hash.ready;

  // operand select for the shared multiplier
  always_comb begin
    case (state)
      S_K1:    op = cmd.word;
      S_K2:    op = prod ^ (prod >> MIX_R);
      S_H1:    op = h;
      S_F0:    op = cmd.has_tail ? (h ^ {8'd0, cmd.tail}) : (h ^ (h >> FIN_S1));
      S_F1:    op = prod ^ (prod >> FIN_S1);
      default: op = h;
    endcase
  end

  assign mul_lo = op * MIX_M;

  // sequencer over the word mix and the final mix
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seed      <= SEED_RESET;
      h         <= SEED_RESET;
      out_valid <= 1'b0;
    end else begin
      // result register: load a finished hash, clear once taken
      if (state == S_F2 && out_free) begin
        out_valid <= 1'b1;
      end else if (hash.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        seed <= cfg_data;
        h    <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            state <= head.has_word ? S_K1 : S_F0;
          end
        end
        S_K1: state <= S_K2;
        S_K2: state <= S_H1;
        S_H1: state <= S_H2;
        S_H2: begin
          h     <= prod ^ k;
          state <= cmd.finish ? S_F0 : S_IDLE;
        end
        S_F0: state <= cmd.has_tail ? S_F1 : S_F2;
        S_F1: state <= S_F2;
        S_F2: begin
          if (out_free) begin
            h     <= seed;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    if (state == S_H1) begin
      k <= prod;
    end
    if (state != S_IDLE && state != S_H2 && state != S_F2) begin
      prod <= mul_lo;
    end
    if (state == S_F2 && out_free) begin
      out_hash <= prod ^ (prod >> FIN_S2);
    end
  end

  assign hash.valid      = out_valid;
  assign hash.hash_value = out_hash;

`include "assert_macros.svh"

  `ASSERT_PROP(a_pop_idle, clk, rst, pop |-> state == S_IDLE)
  `ASSERT_PROP(a_result_from_final, clk, rst, $rose(out_valid) |-> $past(state) == S_F2)
  `ASSERT_PROP(a_word_only_returns, clk, rst, (state == S_H2 && !cmd.finish) |=> state == S_IDLE)

endmodule

`default_nettype wire

// ===== hdl/murmur2_hash_32_top.sv =====
// MurmurHash2-style 32-bit engine (final shifts of 29 and 31 bits, no length
// mixed into the seed). Message bytes arrive one per item on msg; an item with
// last set closes the message and one 32-bit hash comes out on hash. An item
// with has_byte clear and last clear is dropped; with last set it closes the
// message as is (empty message if no bytes came). The front end takes one item
// per cycle while its command queue has room; every fourth byte and every last
// item becomes a command for the back end, which runs all arithmetic through
// one 32x32 multiplier: a word takes the queue pop, three multiplies and the
// fold into the hash, and a finish the final mix. A new command is popped only
// once the last is through; the queue absorbs short bursts. A finish holds in
// its last step while the previous hash is still unread. A write on cfg loads
// the seed and restarts the running hash; cfg is always ready and is meant to
// be written only while no message is in flight.
`default_nettype none

module murmur2_hash_32_top import mm2_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mm2_byte_if.sink   msg,
  mm2_hash_if.source hash,
  mm2_cfg_if.sink    cfg
);

  logic cfg_write;
  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t push_cmd;
  cmd_t head;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid;

  // byte packing and command generation
  mm2_front u_front (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg),
    .cfg_write  (cfg_write),
    .queue_full (full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // command queue
  mm2_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  // hash arithmetic
  mm2_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg.data),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .hash      (hash)
  );

endmodule

`default_nettype wire

// ===== tb/murmur2_hash_32_top_tb.sv =====
`timescale 1ns / 1ps

module murmur2_hash_32_top_tb;
  import mm2_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8 * QUEUE_DEPTH + 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 205;
  localparam int HOLD_PHASE    = 2;
  localparam int DIRECTED_ROWS = 27;

  typedef enum logic {ROW_ITEM, ROW_SEED} row_kind_t;

  // one directed row: an item, or a seed write carried in value
  typedef struct {
    row_kind_t   kind;
    logic [7:0]  data_byte;
    bit          has_byte;
    bit          last;
    bit          known;
    logic [31:0] value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mm2_byte_if msg_if();
  mm2_hash_if hash_if();
  mm2_cfg_if  cfg_if();

  murmur2_hash_32_top uut (
    .clk  (clk),
    .rst  (rst),
    .msg  (msg_if),
    .hash (hash_if),
    .cfg  (cfg_if)
  );

  always #5 clk = ~clk;

  // shadow of the hashing state
  logic [31:0] cur_seed;
  logic [31:0] acc_hash;
  logic [23:0] tail_bytes;
  logic [1:0]  tail_count;

  logic [31:0] pending_digests [$];
  int          error_count = 0;
  int          items_sent  = 0;
  int          cycle_count = 0;
  bit          calm        = 1'b0;
  bit          hold_req    = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // reset seed: empty message, ignored item, single tail byte
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h5a, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
    // zero seed with zero bytes hashes to zero
    '{ROW_SEED, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
    // all-ones seed, two and three byte tails
    '{ROW_SEED, 8'h00, 1'b0, 1'b0, 1'b0, 32'hffff_ffff},
    '{ROW_ITEM, 8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h01, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h02, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h03, 1'b1, 1'b1, 1'b0, 32'h0},
    // word plus tail, ignored item mid message, closed by an item with no byte
    '{ROW_ITEM, 8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h7f, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'haa, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h55, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h12, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'hc3, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h3c, 1'b0, 1'b1, 1'b0, 32'h0},
    // seed write drops a message in progress
    '{ROW_ITEM, 8'ha5, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 8'h5a, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_SEED, 8'h00, 1'b0, 1'b0, 1'b0, 32'h1234_5678},
    '{ROW_ITEM, 8'he7, 1'b1, 1'b1, 1'b0, 32'h0}
  };

  task automatic restart_message();
    acc_hash   = cur_seed;
    tail_bytes = '0;
    tail_count = '0;
  endtask

  // fold one item into the shadow state, give the digest on a last item
  task automatic absorb_item(input logic [7:0] b, input bit hb, input bit lst,
                             output bit done, output logic [31:0] digest);
    logic [31:0] k;
    logic [31:0] h;
    if (hb) begin
      if (tail_count == 2'd3) begin
        k = {b, tail_bytes};
        k = k * MIX_M;
        k = k ^ (k >> MIX_R);
        k = k * MIX_M;
        acc_hash   = (acc_hash * MIX_M) ^ k;
        tail_bytes = '0;
        tail_count = '0;
      end else begin
        tail_bytes[8 * tail_count +: 8] = b;
        tail_count = tail_count + 2'd1;
      end
    end
    done   = lst;
    digest = '0;
    if (lst) begin
      h = acc_hash;
      if (tail_count != 2'd0) begin
        h = (h ^ {8'h00, tail_bytes}) * MIX_M;
      end
      h = h ^ (h >> FIN_S1);
      h = h * MIX_M;
      h = h ^ (h >> FIN_S2);
      digest = h;
      restart_message();
    end
  endtask

  // offer one item from a falling edge, return at the falling edge after it is taken
  task automatic send_item(input logic [7:0] b, input bit hb, input bit lst,
                           input bit known, input logic [31:0] known_hash);
    bit          done;
    logic [31:0] digest;
    if (!calm && $urandom_range(0, 7) == 0) begin
      msg_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    msg_if.valid     <= 1'b1;
    msg_if.data_byte <= b;
    msg_if.has_byte  <= hb;
    msg_if.last      <= lst;
    do @(posedge clk); while (!msg_if.ready);
    absorb_item(b, hb, lst, done, digest);
    if (done) begin
      pending_digests.push_back(known ? known_hash : digest);
    end
    if (hb || lst) begin
      items_sent++;
    end
    @(negedge clk);
  endtask

  // stop sending and let every digest come out, then let the back end settle
  task automatic wait_idle();
    msg_if.valid <= 1'b0;
    while (pending_digests.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] seed);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= seed;
    do @(posedge clk); while (!cfg_if.ready);
    cur_seed = seed;
    restart_message();
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // stimulus: directed table, then random phases with one seed each
  initial begin
    int          target;
    int          len;
    bit          end_empty;
    logic [31:0] seed;
    msg_if.valid     = 1'b0;
    msg_if.data_byte = '0;
    msg_if.has_byte  = 1'b0;
    msg_if.last      = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    cur_seed         = SEED_RESET;
    restart_message();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SEED) begin
        wait_idle();
        write_seed(directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].data_byte, directed_rows[i].has_byte,
                  directed_rows[i].last, directed_rows[i].known, directed_rows[i].value);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      // sometimes leave a message open so the seed write drops it
      if ($urandom_range(0, 1) == 0) begin
        len = $urandom_range(1, 7);
        for (int i = 0; i < len; i++) begin
          send_item(8'($urandom), 1'b1, 1'b0, 1'b0, '0);
        end
      end
      wait_idle();
      if (phase == 0) begin
        seed = 32'h0000_0000;
      end else if (phase == 1) begin
        seed = 32'hffff_ffff;
      end else begin
        seed = $urandom;
      end
      write_seed(seed);
      calm = (phase == PHASES - 1);
      if (phase == HOLD_PHASE) begin
        hold_req = 1'b1;
      end

      // well-formed messages with random content and a few ignored items
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if (hold_req) begin
          len = $urandom_range(0, 3);
        end else if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(13, 64);
        end else begin
          len = $urandom_range(0, 12);
        end
        end_empty = (len == 0) || ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 15) == 0) begin
            send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
          end
          send_item(8'($urandom), 1'b1, (i == len - 1) && !end_empty, 1'b0, '0);
        end
        if (end_empty) begin
          send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
        end
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hash side ready: random stall bursts, one long hold-off on request
  initial begin
    hash_if.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hash_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        hash_if.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hash_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        hash_if.ready <= 1'b1;
      end else begin
        hash_if.ready <= 1'b1;
      end
    end
  end

  // compare each finished hash with the oldest expected digest
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && hash_if.valid && hash_if.ready) begin
      if (pending_digests.size() == 0) begin
        $error("hash_value: no item waiting, actual %08h", hash_if.hash_value);
        error_count++;
      end else begin
        want = pending_digests.pop_front();
        if (hash_if.hash_value !== want) begin
          $error("hash_value mismatch: expected %08h, actual %08h",
                 want, hash_if.hash_value);
          error_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
